// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files atl_isqrt.sv and accel_tilt_angle.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ATL_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ATL_ASSERT_NR(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ATL_ASSERT(name, clk, rst, prop)
`define ATL_ASSERT_NR(name, clk, prop)
`endif
`endif

// ===== src/atl_pkg.sv =====
`timescale 1ns / 1ps
package atl_pkg;
   localparam int DATA_W       = 16;
   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 20;
   localparam int CW           = 36;
   localparam int ZW           = 24;
   localparam int TILT_W       = 15;

   localparam logic [1:0] REG_REF_X = 2'd0;
   localparam logic [1:0] REG_REF_Y = 2'd1;
   localparam logic [1:0] REG_REF_Z = 2'd2;

   localparam logic signed [ZW-1:0] QUARTER_TURN = 24'sd2304000;
   localparam logic signed [ZW-1:0] HALF_TURN    = 24'sd4608000;

   localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      24'sd1152000, 24'sd680065, 24'sd359328, 24'sd182400, 24'sd91554,
      24'sd45822, 24'sd22916, 24'sd11459, 24'sd5730, 24'sd2865,
      24'sd1432, 24'sd716, 24'sd358, 24'sd179, 24'sd90,
      24'sd45, 24'sd22, 24'sd11, 24'sd6, 24'sd3
   };

   typedef struct packed {
      logic deg;
      logic neg;
   } side_type;
endpackage

// ===== src/atl_isqrt.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module atl_isqrt
   import atl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [63:0] in_v,
   input  logic [31:0] in_x,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [32:0] out_root,
   output logic [31:0] out_x,
   output side_type    out_side
);
   logic        valid_ff [SQRT_STEPS];
   logic [63:0] v_ff     [SQRT_STEPS];
   logic [63:0] root_ff  [SQRT_STEPS];
   logic [31:0] x_ff     [SQRT_STEPS];
   side_type    side_ff  [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
      logic        valid_in;
      logic [63:0] v_prev, root_prev, sum, v_in, root_in;
      logic [31:0] x_prev;
      side_type    side_prev;

      if (j == 0) begin : g_first
         assign valid_in  = in_valid;
         assign v_prev    = in_v;
         assign root_prev = '0;
         assign x_prev    = in_x;
         assign side_prev = in_side;
      end else begin : g_next
         assign valid_in  = valid_ff[j-1];
         assign v_prev    = v_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign x_prev    = x_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      always_comb begin
         sum = root_prev + BIT;
         if (v_prev >= sum) begin
            v_in    = v_prev - sum;
            root_in = (root_prev >> 1) + BIT;
         end else begin
            v_in    = v_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_in;
         end
         if (en) begin
            v_ff[j]    <= v_in;
            root_ff[j] <= root_in;
            x_ff[j]    <= x_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1][32:0];
   assign out_x     = x_ff[SQRT_STEPS-1];
   assign out_side  = side_ff[SQRT_STEPS-1];

   `ATL_ASSERT(a_root_range, clock, reset, out_valid |-> root_ff[SQRT_STEPS-1][63:33] == '0)
endmodule

// ===== src/atl_cordic.sv =====
`timescale 1ns / 1ps
module atl_cordic
   import atl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] in_x,
   input  logic signed [CW-1:0] in_y,
   input  side_type             in_side,
   output logic                 out_valid,
   output logic signed [ZW-1:0] out_z,
   output side_type             out_side
);
   logic                 valid_ff [CORDIC_STEPS];
   logic signed [CW-1:0] x_ff     [CORDIC_STEPS];
   logic signed [CW-1:0] y_ff     [CORDIC_STEPS];
   logic signed [ZW-1:0] z_ff     [CORDIC_STEPS];
   side_type             side_ff  [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic                 valid_in;
      logic signed [CW-1:0] x_prev, y_prev, xs, ys, x_in, y_in;
      logic signed [ZW-1:0] z_prev, z_in;
      side_type             side_prev;

      if (i == 0) begin : g_first
         assign valid_in  = in_valid;
         assign x_prev    = in_x;
         assign y_prev    = in_y;
         assign z_prev    = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign valid_in  = valid_ff[i-1];
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      always_comb begin
         xs = x_prev >>> i;
         ys = y_prev >>> i;
         if (!y_prev[CW-1]) begin
            x_in = x_prev + ys;
            y_in = y_prev - xs;
            z_in = z_prev + ATAN_TAB[i];
         end else begin
            x_in = x_prev - ys;
            y_in = y_prev + xs;
            z_in = z_prev - ATAN_TAB[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_in;
         end
         if (en) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_STEPS-1];
   assign out_z     = z_ff[CORDIC_STEPS-1];
   assign out_side  = side_ff[CORDIC_STEPS-1];
endmodule

// ===== src/accel_tilt_angle.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Fields
// req_      in         tdata: accel_x, accel_y, accel_z
// rsp_      out        tdata: tilt_hundredths; tuser: degenerate
// csr_      in         write: ref_x, ref_y, ref_z
//
// One transaction is accepted per cycle while rsp_ is not stalled; each result passes
// through six front stages, 32 square-root stages, 20 CORDIC
// stages and the output register. Reset clears all valid bits and the
// reference registers. A stall on rsp_ holds the whole pipeline in place.
`include "assert_macros.svh"
module accel_tilt_angle
   import atl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x, accel_y, accel_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // tilt_hundredths, one zero pad bit
   output logic [0:0]  rsp_tuser,   // degenerate
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   logic en;
   logic signed [DATA_W-1:0] ref_x_ff, ref_y_ff, ref_z_ff;
   logic signed [DATA_W-1:0] ax, ay, az;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff, qax_ff, qay_ff, qaz_ff, qrx_ff, qry_ff, qrz_ff;
   logic signed [33:0] dot2_ff, dot2_in;
   logic [31:0] na2_ff, nr2_ff;
   logic [63:0] p3_ff, p4_ff, dsq4_ff, c2_5_ff, v6v_ff;
   logic [31:0] dmag3_ff, dmag4_ff, dmag5_ff, x6_ff;
   logic [33:0] mag3_in;
   logic [4:0]  k5_in, k5_ff;
   side_type    side3_ff, side4_ff, side5_ff, side6_ff;

   logic        sq_valid;
   logic [32:0] sq_root;
   logic [31:0] sq_x;
   side_type    sq_side;
   logic                 cd_valid;
   logic signed [ZW-1:0] cd_z;
   side_type             cd_side;
   logic signed [ZW-1:0] zc, zf;
   logic [ZW-1:0]        zr;

   logic              rsp_valid_ff;
   logic [TILT_W-1:0] tilt_ff, tilt_in;
   logic              deg_ff;

   assign en         = rsp_tready || !rsp_valid_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
         ref_z_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_REF_X: ref_x_ff <= csr_wdata;
            REG_REF_Y: ref_y_ff <= csr_wdata;
            REG_REF_Z: ref_z_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign ax = req_tdata[15:0];
   assign ay = req_tdata[31:16];
   assign az = req_tdata[47:32];

   always_comb begin
      dot2_in = 34'(px_ff) + 34'(py_ff) + 34'(pz_ff);
      mag3_in = dot2_ff[33] ? -dot2_ff : dot2_ff;
      k5_in   = '0;
      for (int j = 0; j < 32; j++) begin
         if (p4_ff[2*j +: 2] != 2'b00) begin
            k5_in = 5'(31 - j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
      if (en) begin
         px_ff  <= ax * ref_x_ff;
         py_ff  <= ay * ref_y_ff;
         pz_ff  <= az * ref_z_ff;
         qax_ff <= ax * ax;
         qay_ff <= ay * ay;
         qaz_ff <= az * az;
         qrx_ff <= ref_x_ff * ref_x_ff;
         qry_ff <= ref_y_ff * ref_y_ff;
         qrz_ff <= ref_z_ff * ref_z_ff;

         dot2_ff <= dot2_in;
         na2_ff  <= 32'(qax_ff) + 32'(qay_ff) + 32'(qaz_ff);
         nr2_ff  <= 32'(qrx_ff) + 32'(qry_ff) + 32'(qrz_ff);

         p3_ff        <= 64'(na2_ff) * 64'(nr2_ff);
         dmag3_ff     <= mag3_in[31:0];
         side3_ff.deg <= (na2_ff == '0) || (nr2_ff == '0);
         side3_ff.neg <= dot2_ff[33];

         p4_ff    <= p3_ff;
         dsq4_ff  <= 64'(dmag3_ff) * 64'(dmag3_ff);
         dmag4_ff <= dmag3_ff;
         side4_ff <= side3_ff;

         c2_5_ff  <= p4_ff - dsq4_ff;
         k5_ff    <= k5_in;
         dmag5_ff <= dmag4_ff;
         side5_ff <= side4_ff;

         v6v_ff   <= c2_5_ff << {k5_ff, 1'b0};
         x6_ff    <= dmag5_ff << k5_ff;
         side6_ff <= side5_ff;
      end
   end

   atl_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6_ff),
      .in_v      (v6v_ff),
      .in_x      (x6_ff),
      .in_side   (side6_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_x     (sq_x),
      .out_side  (sq_side)
   );

   atl_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_x      ($signed({4'b0000, sq_x})),
      .in_y      ($signed({3'b000, sq_root})),
      .in_side   (sq_side),
      .out_valid (cd_valid),
      .out_z     (cd_z),
      .out_side  (cd_side)
   );

   always_comb begin
      if (cd_z < 0) begin
         zc = '0;
      end else if (cd_z > QUARTER_TURN) begin
         zc = QUARTER_TURN;
      end else begin
         zc = cd_z;
      end
      zf = cd_side.neg ? (HALF_TURN - zc) : zc;
      zr = zf + 24'sd128;
      tilt_in = cd_side.deg ? '0 : zr[8 +: TILT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cd_valid;
      end
      if (en) begin
         tilt_ff <= tilt_in;
         deg_ff  <= cd_side.deg;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, tilt_ff};
   assign rsp_tuser  = deg_ff;

   `ATL_ASSERT(a_deg_zero, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
   `ATL_ASSERT(a_tilt_range, clock, reset, rsp_tvalid |-> rsp_tdata[14:0] <= 15'd18000)
   `ATL_ASSERT_NR(a_reset_clear, clock, reset |=> !rsp_tvalid)
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import atl_pkg::*;

   localparam int LATENCY = 59;
   localparam int RANDOM_SAMPLES = 1500;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic [TILT_W-1:0] tilt;
      logic              deg;
   } tilt_result_type;

   typedef struct {
      logic [15:0] ax;
      logic [15:0] ay;
      logic [15:0] az;
      logic        typed;
      logic [TILT_W-1:0] tilt;
      logic        deg;
   } sample_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   logic [15:0] ref_vec [3];
   tilt_result_type pending_tilts [$];
   int error_count;
   int result_count;
   longint cycle_count;
   logic stall_mode;

   accel_tilt_angle dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint sx16(logic [15:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic tilt_result_type predict_tilt(logic [15:0] ax, logic [15:0] ay,
                                                    logic [15:0] az);
      tilt_result_type r;
      longint dot, x, y, z, xs, ys;
      longint unsigned na2, nr2, p, c2, dmag;
      int k;
      dot = sx16(ax) * sx16(ref_vec[0]) + sx16(ay) * sx16(ref_vec[1])
            + sx16(az) * sx16(ref_vec[2]);
      na2 = sx16(ax) * sx16(ax) + sx16(ay) * sx16(ay) + sx16(az) * sx16(az);
      nr2 = sx16(ref_vec[0]) * sx16(ref_vec[0]) + sx16(ref_vec[1]) * sx16(ref_vec[1])
            + sx16(ref_vec[2]) * sx16(ref_vec[2]);
      if (na2 == 0 || nr2 == 0) begin
         r.tilt = '0;
         r.deg = 1'b1;
         return r;
      end
      p = na2 * nr2;
      dmag = (dot < 0) ? -dot : dot;
      c2 = p - dmag * dmag;
      k = 0;
      while (p < (64'd1 << 62)) begin
         p = p << 2;
         k++;
      end
      x = dmag << k;
      y = int_sqrt(c2 << (2 * k));
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = shift_floor(x, i);
         ys = shift_floor(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_TAB[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_TAB[i];
         end
      end
      if (z < 0) z = 0;
      if (z > QUARTER_TURN) z = QUARTER_TURN;
      if (dot < 0) z = HALF_TURN - z;
      r.tilt = TILT_W'((z + 128) >>> 8);
      r.deg = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count <= result_count + 1;
         if (pending_tilts.size() == 0) begin
            $error("unexpected result transaction tilt=%0d", rsp_tdata[TILT_W-1:0]);
            error_count++;
         end else begin
            tilt_result_type e;
            e = pending_tilts.pop_front();
            if (rsp_tdata[TILT_W-1:0] !== e.tilt) begin
               $error("tilt_hundredths expected %0d actual %0d", e.tilt,
                      rsp_tdata[TILT_W-1:0]);
               error_count++;
            end
            if (rsp_tuser[0] !== e.deg) begin
               $error("degenerate expected %0d actual %0d", e.deg, rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   // The receiver alternates between random stalls and long runs without any.
   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
      if (reset) rsp_tready <= 1'b0;
      else if (stall_mode) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= 1'b1;
   end

   task automatic write_ref(logic [1:0] index, logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index <= REG_REF_Z) ref_vec[index] = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_reference(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      while (pending_tilts.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      write_ref(REG_REF_X, x);
      write_ref(REG_REF_Y, y);
      write_ref(REG_REF_Z, z);
   endtask

   // Called at a falling edge; returns at a falling edge with tvalid still high.
   task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                              logic typed, tilt_result_type typed_res);
      tilt_result_type r;
      r = typed ? typed_res : predict_tilt(ax, ay, az);
      req_tvalid <= 1'b1;
      req_tdata <= {az, ay, ax};
      do @(posedge clock); while (!req_tready);
      pending_tilts.push_back(r);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 4)) - 16'd2;
         default: return 16'($urandom);
      endcase
   endfunction

   sample_row_type directed_rows [] = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b1, 15'd0, 1'b1},
      '{16'h4000, 16'h0000, 16'h0000, 1'b1, 15'd0, 1'b0},
      '{16'h7FFF, 16'h0000, 16'h0000, 1'b1, 15'd0, 1'b0},
      '{16'hC000, 16'h0000, 16'h0000, 1'b1, 15'd18000, 1'b0},
      '{16'h8000, 16'h0000, 16'h0000, 1'b1, 15'd18000, 1'b0},
      '{16'h0000, 16'h4000, 16'h0000, 1'b0, 15'd0, 1'b0},
      '{16'h0000, 16'h0000, 16'h8000, 1'b0, 15'd0, 1'b0},
      '{16'h4000, 16'h4000, 16'h0000, 1'b0, 15'd0, 1'b0},
      '{16'hC000, 16'h4000, 16'h0000, 1'b0, 15'd0, 1'b0},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 15'd0, 1'b0},
      '{16'h8000, 16'h8000, 16'h8000, 1'b0, 15'd0, 1'b0},
      '{16'h0001, 16'h0000, 16'h0000, 1'b1, 15'd0, 1'b0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 15'd0, 1'b0},
      '{16'h0001, 16'hFFFF, 16'h7FFF, 1'b0, 15'd0, 1'b0}
   };

   initial begin
      tilt_result_type none;
      tilt_result_type deg_res;
      int drain;
      none = '{tilt: '0, deg: 1'b0};
      deg_res = '{tilt: '0, deg: 1'b1};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_tready = 1'b0;
      stall_mode = 1'b0;
      error_count = 0;
      result_count = 0;
      cycle_count = 0;
      for (int i = 0; i < 3; i++) ref_vec[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The reference is zero after reset, so every sample is degenerate.
      send_sample(16'h1234, 16'h0000, 16'h0000, 1'b1, deg_res);
      send_sample(16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, deg_res);
      req_tvalid <= 1'b0;

      set_reference(16'h4000, 16'h0000, 16'h0000);
      // An out-of-range register index must leave the reference unchanged.
      write_ref(2'd3, 16'h5555);
      foreach (directed_rows[i]) begin
         sample_row_type row;
         row = directed_rows[i];
         send_sample(row.ax, row.ay, row.az, row.typed, '{tilt: row.tilt, deg: row.deg});
      end
      req_tvalid <= 1'b0;
      set_reference(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, none);
      send_sample(16'h8000, 16'h8000, 16'h8000, 1'b1, none);
      req_tvalid <= 1'b0;
      set_reference(16'h7FFF, 16'h0001, 16'hFFFF);
      send_sample(16'h0001, 16'h0000, 16'h0000, 1'b0, none);
      send_sample(16'h0000, 16'h0000, 16'h0000, 1'b1, deg_res);

      for (int n = 0; n < RANDOM_SAMPLES; n++) begin
         if (n % 300 == 299) begin
            req_tvalid <= 1'b0;
            if (n == 599) set_reference(16'h0000, 16'h0000, 16'h0000);
            else set_reference(rand_axis(), rand_axis(), rand_axis());
         end
         if ($urandom_range(0, 199) == 0)
            send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0, none);
         else if ($urandom_range(0, 9) == 0)
            send_sample(ref_vec[0], ref_vec[1], ref_vec[2], 1'b0, none);
         else
            send_sample(rand_axis(), rand_axis(), rand_axis(), 1'b0, none);
         idle_gap();
      end
      req_tvalid <= 1'b0;

      while (pending_tilts.size() != 0) @(negedge clock);
      drain = 0;
      while (drain < LATENCY + 20) begin
         @(negedge clock);
         drain++;
      end
      $display("Checked %0d result transactions over directed extremes and %0d random samples",
               result_count, RANDOM_SAMPLES);
      $display("under several reference vectors, including zero and full-scale references.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
